/* rtl/qat_pkg.sv */
// Package for the quoted argument tokenizer: codes, character constants and helpers.
`timescale 1ns / 1ps

package qat_pkg;

    typedef enum logic [1:0] {
        QK_NONE = 2'd0,
        QK_APOS = 2'd1,
        QK_TICK = 2'd2,
        QK_DQ   = 2'd3
    } quote_kind_t;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_APOS      = 8'h27;
    localparam logic [7:0] CH_TICK      = 8'h60;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_VTAB      = 8'h0B;
    localparam logic [7:0] CH_FORMFEED  = 8'h0C;
    localparam logic [7:0] CH_CR        = 8'h0D;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic REG_PROMPT_ENABLE = 1'b0;

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE) ||
                   (c == CH_VTAB) || (c == CH_FORMFEED) || (c == CH_CR);
    endfunction

endpackage

/* rtl/qat_stream_if.sv */
// Byte and token stream interfaces with valid/ready handshake.
`timescale 1ns / 1ps

interface qat_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface qat_token_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       word_end;
    logic       prompt_due;

    modport source (output valid, output out_byte, output byte_valid, output word_end,
                    output prompt_due, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input word_end,
                    input prompt_due, output ready);
endinterface

/* rtl/quoted_argument_tokenizer_unit.sv */
// Top level of the quoted argument tokenizer.
//
// Usage: bytes arrive on the stream channel (in_byte, or end_of_input with
// no byte), one beat per byte. Every accepted beat yields exactly one beat on
// the token channel: a word byte (byte_valid), a word end flag (word_end),
// both, or neither, plus prompt_due, the prompt flag as it stood before it.
// Quote and escape state, word length and the prompt flag are held in a
// small state register updated as each beat is accepted.
// The token beat is registered: it shows the cycle after its input is taken.
// Throughput: one beat per cycle; the result register frees as its beat is
// taken, so a new byte is accepted in the same cycle the previous token
// leaves. When the receiver stalls, the token beat holds and stream.ready
// drops until it is taken.
// Reset (rst_n, async, active low) clears control state and prompt_enable; the
// prompt flag starts equal to prompt_enable. Writing prompt_enable over APB
// (paddr[2] clear, bit 0) also reloads the prompt flag with the new value.
// Words longer than MAX_WORD_BYTES are split at that length.
`timescale 1ns / 1ps

module quoted_argument_tokenizer_unit #(
    parameter int unsigned MAX_WORD_BYTES = 127
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [qat_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [qat_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [qat_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    qat_byte_if.sink                          stream,
    qat_token_if.source                       token
);

    localparam int unsigned LEN_W = $clog2(MAX_WORD_BYTES + 1);
    localparam logic [LEN_W:0] LEN_MAX = (LEN_W + 1)'(MAX_WORD_BYTES);

    logic                  prompt_enable_reg;
    logic                  prompt_pending_reg, prompt_pending_next;
    logic                  escape_reg, escape_next;
    qat_pkg::quote_kind_t  quote_reg, quote_next;
    logic                  started_reg, started_next;
    logic [LEN_W-1:0]      length_reg, length_next;

    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic                  byte_valid_reg, byte_valid_next;
    logic                  word_end_reg, word_end_next;
    logic                  prompt_due_reg;

    logic                  accept;
    logic                  cfg_write;
    logic                  take;
    logic [LEN_W:0]        length_inc;
    logic [7:0]            closer;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite &&
                       (paddr[qat_pkg::APB_ADDR_W-1] == qat_pkg::REG_PROMPT_ENABLE);
    assign prdata    = (paddr[qat_pkg::APB_ADDR_W-1] == qat_pkg::REG_PROMPT_ENABLE) ?
                       {{(qat_pkg::APB_DATA_W-1){1'b0}}, prompt_enable_reg} : '0;

    assign stream.ready = !out_valid_reg || token.ready;
    assign accept       = stream.valid && stream.ready;

    assign token.valid      = out_valid_reg;
    assign token.out_byte   = out_byte_reg;
    assign token.byte_valid = byte_valid_reg;
    assign token.word_end   = word_end_reg;
    assign token.prompt_due = prompt_due_reg;

    assign length_inc = {1'b0, length_reg} + (LEN_W + 1)'(1);
    assign closer     = (quote_reg == qat_pkg::QK_DQ) ? qat_pkg::CH_DQUOTE : qat_pkg::CH_APOS;

    always_comb
    begin
        take                = 1'b0;
        word_end_next       = 1'b0;
        escape_next         = escape_reg;
        quote_next          = quote_reg;
        started_next        = started_reg;
        length_next         = length_reg;
        prompt_pending_next = 1'b0;

        if (stream.end_of_input)
        begin
            word_end_next = started_reg;
        end
        else if (escape_reg)
        begin
            escape_next = 1'b0;
            take        = (stream.in_byte != qat_pkg::CH_NEWLINE);
        end
        else if (stream.in_byte == qat_pkg::CH_BACKSLASH)
        begin
            escape_next = 1'b1;
        end
        else if (quote_reg != qat_pkg::QK_NONE)
        begin
            if (stream.in_byte == closer)
                quote_next = qat_pkg::QK_NONE;
            else
                take = 1'b1;
        end
        else if (stream.in_byte == qat_pkg::CH_APOS)
        begin
            quote_next = qat_pkg::QK_APOS;
        end
        else if (stream.in_byte == qat_pkg::CH_TICK)
        begin
            quote_next = qat_pkg::QK_TICK;
        end
        else if (stream.in_byte == qat_pkg::CH_DQUOTE)
        begin
            quote_next = qat_pkg::QK_DQ;
        end
        else if (qat_pkg::is_blank(stream.in_byte))
        begin
            if (stream.in_byte == qat_pkg::CH_NEWLINE)
                prompt_pending_next = prompt_enable_reg;
            word_end_next = started_reg;
        end
        else
        begin
            take = 1'b1;
        end

        if (take)
        begin
            started_next = 1'b1;
            length_next  = length_inc[LEN_W-1:0];
            if (length_inc >= LEN_MAX)
                word_end_next = 1'b1;
        end
        if (word_end_next)
        begin
            started_next = 1'b0;
            length_next  = '0;
        end

        byte_valid_next = take;
        out_byte_next   = take ? stream.in_byte : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prompt_enable_reg  <= 1'b0;
            prompt_pending_reg <= 1'b0;
            escape_reg         <= 1'b0;
            quote_reg          <= qat_pkg::QK_NONE;
            started_reg        <= 1'b0;
            length_reg         <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                prompt_enable_reg  <= pwdata[0];
                prompt_pending_reg <= pwdata[0];
            end
            else if (accept)
            begin
                prompt_pending_reg <= prompt_pending_next;
            end

            if (accept)
            begin
                escape_reg  <= escape_next;
                quote_reg   <= quote_next;
                started_reg <= started_next;
                length_reg  <= length_next;
            end

            if (accept)
                out_valid_reg <= 1'b1;
            else if (token.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded only with a new beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_byte_reg   <= out_byte_next;
            byte_valid_reg <= byte_valid_next;
            word_end_reg   <= word_end_next;
            prompt_due_reg <= prompt_pending_reg;
        end
    end

endmodule

/* rtl/qat_checker.sv */
// Port-level assertions for the quoted argument tokenizer, with bind.
`timescale 1ns / 1ps

module qat_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       end_of_input,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       word_end,
    input logic       prompt_due
);

    // held token beat keeps its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
        $stable(byte_valid) && $stable(word_end) && $stable(prompt_due))
        else $error("token beat changed while stalled");

    a_zero_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_byte == 8'h00)
        else $error("out_byte nonzero without byte_valid");

    a_no_invented_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("token beat without input beat");

    a_eoi_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_input |=> out_valid && !byte_valid)
        else $error("end of input produced a word byte");

endmodule

bind quoted_argument_tokenizer_unit qat_checker u_qat_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (stream.valid),
    .in_ready     (stream.ready),
    .end_of_input (stream.end_of_input),
    .out_valid    (token.valid),
    .out_ready    (token.ready),
    .out_byte     (token.out_byte),
    .byte_valid   (token.byte_valid),
    .word_end     (token.word_end),
    .prompt_due   (token.prompt_due)
);
